[rtl/lrufa_pkg.sv]
// lrufa_pkg: shared field widths and the control group that drives the cell row
// of the lru lookup unit. No dependencies.

package lrufa_pkg;

  // widths of the channel fields
  localparam int ACCESS_KEY_W   = 32;
  localparam int HIT_POSITION_W = 4;
  localparam int ACTIVE_WAYS_W  = 5;

  // reset value of the active way count
  localparam logic [ACTIVE_WAYS_W-1:0] ACTIVE_WAYS_RESET = 5'd16;

  // control broadcast from the top level to every cell
  typedef struct packed {
    logic compare;  // latch the match flag against the incoming key
    logic update;   // apply the recency update
    logic hit;      // some cell matched
    logic full;     // miss with every way in use, evict the front
  } cell_ctrl_t;

endpackage

[rtl/lrufa_ifs.sv]
// lrufa_ifs: valid/ready channel interfaces of the lru lookup unit
// (request, response, configuration write). Depends on lrufa_pkg.

interface lrufa_req_if;
  logic                                valid;
  logic                                ready;
  logic [lrufa_pkg::ACCESS_KEY_W-1:0]  access_key;

  modport source (output valid, output access_key, input ready);
  modport sink   (input valid, input access_key, output ready);
endinterface

interface lrufa_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 hit;
  logic [lrufa_pkg::HIT_POSITION_W-1:0] hit_position;
  logic                                 evicted_valid;
  logic [lrufa_pkg::ACCESS_KEY_W-1:0]   evicted_key;

  modport source (output valid, output hit, output hit_position, output evicted_valid,
                  output evicted_key, input ready);
  modport sink   (input valid, input hit, input hit_position, input evicted_valid,
                  input evicted_key, output ready);
endinterface

interface lrufa_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [lrufa_pkg::ACTIVE_WAYS_W-1:0] active_ways;

  modport source (output valid, output active_ways, input ready);
  modport sink   (input valid, input active_ways, output ready);
endinterface

[rtl/lru_fully_associative_lookup_unit.sv]
// lru_fully_associative_lookup_unit: top level of the fully associative lru lookup.
// Holds the row of lrufa_cell slots, the fill count and the response register.
// Depends on lrufa_pkg, lrufa_ifs and lrufa_cell.
//
// Usage
//   req : one access key per request; cfg : write of active_ways (1..WAYS in use,
//   0 acts as 1, larger values act as WAYS), to be written by the user only while the
//   unit is idle, which the unit itself does not enforce. rsp : one response per
//   request with hit, hit_position, evicted_valid and evicted_key.
// Timing
//   A request is compared against all slots at the accept edge, which latches the
//   match flags; in the update state the row shifts and the response register
//   loads. A new request is accepted only after the previous one has left the
//   update state; the compare-then-shift pass through the cell row keeps it busy.
//   While the response waits for rsp.ready the next request is still accepted;
//   its update stalls until the response register is free.
// Reset
//   rst clears the fill count, the response valid and restores active_ways to 16.
//   Slot contents are not cleared; only slots below the fill count are ever read.

module lru_fully_associative_lookup_unit #(
  parameter int WAYS     = 16,
  parameter int KEY_BITS = 32
) (
  input  logic         clk,
  input  logic         rst,
  lrufa_req_if.sink    req,
  lrufa_rsp_if.source  rsp,
  lrufa_cfg_if.sink    cfg
);

  localparam int FILL_W = $clog2(WAYS + 1);
  localparam int POS_W  = (WAYS > 1) ? $clog2(WAYS) : 1;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_UPD  = 2'b10
  } state_t;

  state_t                               state;
  state_t                               state_next;
  logic [lrufa_pkg::ACTIVE_WAYS_W-1:0]  active_ways;
  logic [FILL_W-1:0]                    fill;
  logic [FILL_W-1:0]                    fill_clamp;
  logic [FILL_W-1:0]                    fill_next;
  logic [FILL_W-1:0]                    ways;
  logic [FILL_W-1:0]                    cell_fill;
  logic [KEY_BITS-1:0]                  in_key;
  logic [KEY_BITS-1:0]                  key;
  logic                                 req_fire;
  logic                                 rsp_free;
  logic                                 do_update;
  logic                                 hit_any;
  logic                                 full;
  logic [POS_W-1:0]                     pos;
  lrufa_pkg::cell_ctrl_t                ctrl;
  logic [KEY_BITS-1:0]                  entry   [WAYS];
  logic [KEY_BITS-1:0]                  nbr     [WAYS];
  logic [WAYS-1:0]                      match;
  logic [WAYS:0]                        seen;

  // handshakes
  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign req_fire  = req.valid && req.ready;
  assign rsp_free  = !rsp.valid || rsp.ready;
  assign do_update = (state == S_UPD) && rsp_free;

  // key kept to KEY_BITS bits
  assign in_key = KEY_BITS'(req.access_key);

  // ways in use, clamped to 1..WAYS
  always_comb begin
    if (active_ways == '0) begin
      ways = FILL_W'(1);
    end else if (int'(active_ways) > WAYS) begin
      ways = FILL_W'(WAYS);
    end else begin
      ways = FILL_W'(active_ways);
    end
  end

  // fill count cut to the ways in use at each access
  assign fill_clamp = (fill > ways) ? ways : fill;
  assign cell_fill  = (state == S_IDLE) ? fill_clamp : fill;

  // hit detection and position encode over the latched match flags
  assign hit_any = |match;
  assign full    = !hit_any && (fill == ways);

  always_comb begin
    pos = '0;
    for (int i = 0; i < WAYS; i++) begin
      if (match[i]) begin
        pos = pos | POS_W'(i);
      end
    end
  end

  // cell control
  assign ctrl.compare = req_fire;
  assign ctrl.update  = do_update;
  assign ctrl.hit     = hit_any;
  assign ctrl.full    = full;

  // cell row, each slot hands its key down to the slot below
  assign seen[0] = 1'b0;

  for (genvar g = 0; g < WAYS; g++) begin : g_cell
    if (g + 1 < WAYS) begin : g_nbr
      assign nbr[g] = entry[g + 1];
    end else begin : g_last
      assign nbr[g] = '0;
    end

    lrufa_cell #(
      .KEY_BITS (KEY_BITS),
      .FILL_W   (FILL_W),
      .IDX      (g)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .fill       (cell_fill),
      .cmp_key    (in_key),
      .upd_key    (key),
      .next_entry (nbr[g]),
      .seen_in    (seen[g]),
      .entry      (entry[g]),
      .match      (match[g]),
      .seen_out   (seen[g + 1])
    );
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_fire) begin
          state_next = S_UPD;
        end
      end
      S_UPD: begin
        if (do_update) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // fill count after the update
  assign fill_next = (hit_any || full) ? fill : fill + FILL_W'(1);

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      fill        <= '0;
      active_ways <= lrufa_pkg::ACTIVE_WAYS_RESET;
    end else begin
      state <= state_next;
      if (cfg.valid && cfg.ready) begin
        active_ways <= cfg.active_ways;
      end
      if (req_fire) begin
        fill <= fill_clamp;
      end else if (do_update) begin
        fill <= fill_next;
      end
    end
  end

  // latched request key
  always_ff @(posedge clk) begin
    if (req_fire) begin
      key <= in_key;
    end
  end

  // response valid
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (do_update) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  // response payload
  always_ff @(posedge clk) begin
    if (do_update) begin
      rsp.hit           <= hit_any;
      rsp.hit_position  <= lrufa_pkg::HIT_POSITION_W'(pos);
      rsp.evicted_valid <= full;
      rsp.evicted_key   <= full ? lrufa_pkg::ACCESS_KEY_W'(entry[0]) : '0;
    end
  end

`ifndef SYNTHESIS
  // stored keys are unique, so at most one slot matches
  a_match_onehot: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPD) |-> $onehot0(match))
    else $error("more than one slot matched the key");

  // the fill count never passes the ways in use after an update
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    do_update |=> (fill <= ways))
    else $error("fill count exceeds ways in use");

  // an accepted request always moves to the update step
  a_accept_upd: assert property (@(posedge clk) disable iff (rst)
    req_fire |=> (state == S_UPD))
    else $error("accepted request did not reach the update step");

  // a hit never reports an eviction
  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !(rsp.hit && rsp.evicted_valid))
    else $error("response reports both hit and eviction");
`endif

endmodule

[rtl/lrufa_cell.sv]
// lrufa_cell: one recency slot of the lru stack. Holds a key, compares it,
// and takes its neighbor's key when the stack shifts. Depends on lrufa_pkg.

module lrufa_cell #(
  parameter int KEY_BITS = 32,
  parameter int FILL_W   = 5,
  parameter int IDX      = 0
) (
  input  logic                  clk,
  input  lrufa_pkg::cell_ctrl_t ctrl,
  input  logic [FILL_W-1:0]     fill,
  input  logic [KEY_BITS-1:0]   cmp_key,
  input  logic [KEY_BITS-1:0]   upd_key,
  input  logic [KEY_BITS-1:0]   next_entry,
  input  logic                  seen_in,
  output logic [KEY_BITS-1:0]   entry,
  output logic                  match,
  output logic                  seen_out
);

  localparam logic [FILL_W-1:0] POS      = FILL_W'(IDX);
  localparam logic [FILL_W-1:0] POS_NEXT = FILL_W'(IDX + 1);

  logic valid;
  logic below_top;
  logic at_top;
  logic shift;

  assign valid     = POS < fill;
  assign below_top = POS_NEXT < fill;
  assign at_top    = POS_NEXT == fill;

  // a hit at or below this slot has been seen along the chain
  assign seen_out = seen_in | match;

  // hit: slots from the hit up to just below the top shift; full miss: every slot below the top shifts
  assign shift = below_top && (ctrl.hit ? seen_out : ctrl.full);

  // match flag, latched at request accept
  always_ff @(posedge clk) begin
    if (ctrl.compare) begin
      match <= valid && (entry == cmp_key);
    end
  end

  // recency update
  always_ff @(posedge clk) begin
    if (ctrl.update) begin
      if (shift) begin
        entry <= next_entry;
      end else if ((ctrl.hit || ctrl.full) && at_top) begin
        entry <= upd_key;
      end else if (!ctrl.hit && !ctrl.full && (POS == fill)) begin
        entry <= upd_key;
      end
    end
  end

endmodule

[test/tb_top.sv]
// tb_top: self-checking bench for lru_fully_associative_lookup_unit, with a shadow lru
// stack that predicts every response, random flow control and way-count sweeps.
// Depends on lrufa_pkg, lrufa_ifs and the unit itself.

module tb_top;

  localparam int WAYS       = 16;
  localparam int LIMIT      = 500000;
  localparam int LONG_HOLD  = 300;
  localparam int NUM_PHASES = 9;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic                                 hit;
    logic [lrufa_pkg::HIT_POSITION_W-1:0] hit_position;
    logic                                 evicted_valid;
    logic [lrufa_pkg::ACCESS_KEY_W-1:0]   evicted_key;
  } lookup_result_t;

  // phase plan: way count, idling, long receiver hold, request count
  logic [lrufa_pkg::ACTIVE_WAYS_W-1:0] phase_ways[NUM_PHASES] =
    '{5'd16, 5'd4, 5'd1, 5'd31, 5'd0, 5'd9, 5'd17, 5'd2, 5'd16};
  idle_mode_t phase_idle[NUM_PHASES] = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH,
                                         IDLE_NONE, IDLE_NONE, IDLE_SEND, IDLE_RECV,
                                         IDLE_BOTH};
  bit phase_hold[NUM_PHASES]   = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0};
  int phase_count[NUM_PHASES]  = '{300, 250, 150, 300, 100, 200, 200, 150, 250};

  logic clk = 1'b0;
  logic rst;

  lrufa_req_if req_ch ();
  lrufa_rsp_if rsp_ch ();
  lrufa_cfg_if cfg_ch ();

  lru_fully_associative_lookup_unit #(
    .WAYS     (WAYS),
    .KEY_BITS (lrufa_pkg::ACCESS_KEY_W)
  ) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  always #5 clk = ~clk;

  // shadow copy of the unit state
  logic [lrufa_pkg::ACCESS_KEY_W-1:0]  shadow_stack[WAYS];
  int                                  shadow_fill;
  logic [lrufa_pkg::ACTIVE_WAYS_W-1:0] shadow_ways;

  lookup_result_t expected_lookups[$];
  logic [lrufa_pkg::ACCESS_KEY_W-1:0] pending_keys[$];
  logic [lrufa_pkg::ACCESS_KEY_W-1:0] key_pool[$];

  int outstanding  = 0;
  int errors       = 0;
  int lookups_seen = 0;
  int hits_seen    = 0;
  int evicts_seen  = 0;
  int cfg_writes   = 0;
  int cycle_count  = 0;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_asked     = 0;
  int hold_served    = 0;
  int hold_left      = 0;

  // way count actually in use for a register value
  function automatic int ways_in_use(logic [lrufa_pkg::ACTIVE_WAYS_W-1:0] w);
    int n;
    n = int'(w);
    if (n == 0) n = 1;
    if (n > WAYS) n = WAYS;
    return n;
  endfunction

  // one lookup against the shadow stack, returns the response it should produce
  function automatic lookup_result_t lru_access(logic [lrufa_pkg::ACCESS_KEY_W-1:0] key);
    lookup_result_t r;
    int ways;
    int fill;
    int pos;
    bit found;
    ways  = ways_in_use(shadow_ways);
    fill  = shadow_fill;
    pos   = 0;
    found = 1'b0;
    r     = '0;
    // a shrunken way count drops the most recent entries
    if (fill > ways) fill = ways;
    for (int i = 0; i < fill; i++) begin
      if (shadow_stack[i] == key) begin
        found = 1'b1;
        pos   = i;
      end
    end
    if (found) begin
      for (int i = pos; i + 1 < fill; i++) shadow_stack[i] = shadow_stack[i + 1];
      shadow_stack[fill - 1] = key;
    end else if (fill < ways) begin
      shadow_stack[fill] = key;
      fill++;
    end else begin
      r.evicted_valid = 1'b1;
      r.evicted_key   = shadow_stack[0];
      for (int i = 0; i + 1 < ways; i++) shadow_stack[i] = shadow_stack[i + 1];
      shadow_stack[ways - 1] = key;
    end
    shadow_fill    = fill;
    r.hit          = found;
    r.hit_position = pos[lrufa_pkg::HIT_POSITION_W-1:0];
    return r;
  endfunction

  // request driver, fed from pending_keys
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        expected_lookups = {expected_lookups, lru_access(req_ch.access_key)};
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (pending_keys.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req_ch.valid      <= 1'b1;
          req_ch.access_key <= pending_keys.pop_front();
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, counted here
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_asked) begin
      hold_served <= hold_asked;
      hold_left   <= LONG_HOLD;
    end
  end

  // response monitor and checker
  always @(posedge clk) begin : rsp_monitor
    lookup_result_t got;
    lookup_result_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        got.hit           = rsp_ch.hit;
        got.hit_position  = rsp_ch.hit_position;
        got.evicted_valid = rsp_ch.evicted_valid;
        got.evicted_key   = rsp_ch.evicted_key;
        if (expected_lookups.size() == 0) begin
          errors++;
          $display("%0t: unexpected response hit=%0d pos=%0d ev=%0d key=%h", $time,
                   got.hit, got.hit_position, got.evicted_valid, got.evicted_key);
        end else begin
          want = expected_lookups.pop_front();
          outstanding--;
          lookups_seen++;
          if (want.hit) hits_seen++;
          if (want.evicted_valid) evicts_seen++;
          if (got !== want) begin
            errors++;
            $display("%0t: mismatch expected hit=%0d pos=%0d ev=%0d key=%h", $time,
                     want.hit, want.hit_position, want.evicted_valid, want.evicted_key);
            $display("%0t:          actual   hit=%0d pos=%0d ev=%0d key=%h", $time,
                     got.hit, got.hit_position, got.evicted_valid, got.evicted_key);
          end
        end
      end
      rsp_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // run limit
  initial begin
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d responses outstanding", cycle_count, outstanding);
    $display("FAIL");
    $finish;
  end

  task automatic queue_key(input logic [lrufa_pkg::ACCESS_KEY_W-1:0] key);
    pending_keys = {pending_keys, key};
    outstanding++;
  endtask

  // wait until every queued request has its response, then let the unit settle
  task automatic drain();
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // configuration write, only issued while the unit is idle
  task automatic write_ways(input logic [lrufa_pkg::ACTIVE_WAYS_W-1:0] ways);
    cfg_ch.valid       <= 1'b1;
    cfg_ch.active_ways <= ways;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    shadow_ways = ways;
    cfg_writes++;
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_idling(input idle_mode_t mode);
    send_idle_pct  <= (mode == IDLE_SEND) ? 77 : (mode == IDLE_BOTH) ? 6 : 0;
    recv_stall_pct <= (mode == IDLE_RECV) ? 77 : (mode == IDLE_BOTH) ? 6 : 0;
  endtask

  // mostly keys from a small pool so hits and evictions both happen
  function automatic logic [lrufa_pkg::ACCESS_KEY_W-1:0] pick_key();
    if ($urandom_range(99) < 12) return $urandom;
    return key_pool[$urandom_range(key_pool.size() - 1)];
  endfunction

  initial begin
    int ways;
    int pool_n;
    req_ch.valid       = 1'b0;
    req_ch.access_key  = '0;
    rsp_ch.ready       = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.active_ways = '0;
    rst                = 1'b1;
    shadow_fill        = 0;
    shadow_ways        = lrufa_pkg::ACTIVE_WAYS_RESET;
    foreach (shadow_stack[i]) shadow_stack[i] = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: key extremes, hit at front and back, fill to full, evictions
    queue_key(32'h0000_0000);
    queue_key(32'hFFFF_FFFF);
    queue_key(32'h0000_0000);
    for (int i = 1; i <= 14; i++) queue_key(i);
    queue_key(32'hFFFF_FFFF);
    queue_key(32'hFFFF_FFFF);
    queue_key(32'hA5A5_A5A5);
    queue_key(32'h0000_0000);
    drain();

    // zero ways acts as one, and the fill count is cut below the old fill
    write_ways(5'd0);
    queue_key(32'h1234_5678);
    queue_key(32'h1234_5678);
    queue_key(32'h8000_0001);
    drain();

    // random phases
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_ways(phase_ways[p]);
      set_idling(phase_idle[p]);
      ways   = ways_in_use(phase_ways[p]);
      pool_n = $urandom_range(ways + 4, ways / 2 + 1);
      key_pool.delete();
      for (int i = 0; i < pool_n; i++) key_pool = {key_pool, $urandom};
      @(posedge clk);
      if (phase_hold[p]) hold_asked <= hold_asked + 1;
      for (int i = 0; i < phase_count[p]; i++) queue_key(pick_key());
      drain();
    end

    $display("covered %0d lookups (%0d hits, %0d evictions) over %0d way-count writes",
             lookups_seen, hits_seen, evicts_seen, cfg_writes);
    $display("including zero and oversized way counts, shrink below fill, long output stall");
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAIL");
    end
    $finish;
  end

endmodule

[files.f]
rtl/lrufa_pkg.sv
rtl/lrufa_ifs.sv
rtl/lrufa_cell.sv
rtl/lru_fully_associative_lookup_unit.sv
test/tb_top.sv
